@@ hw/rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and constants of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int BUFFER_MAX_DEF = 64;

  // timer and retry constants
  localparam logic [32:0] TIMEOUT_FIRST = 33'd100000;
  localparam logic [32:0] TIMEOUT_RETX  = 33'd300000;
  localparam logic [15:0] SEQ_EARLY     = 16'd10;
  localparam logic [2:0]  RETRY_LIMIT   = 3'd5;
  localparam logic [2:0]  RETRY_SAT     = 3'd7;

  // divider widths
  localparam int DVD_W = 49;
  localparam int DVS_W = 17;
  localparam int DCW   = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_WIN_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_BUF_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ACK_TARGET = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SEND    = 3'd1;
  localparam logic [2:0] KIND_RETX    = 3'd2;
  localparam logic [2:0] KIND_TAKEN   = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  typedef struct packed {
    logic        func;
    logic [15:0] ack_seq;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic        last;
    logic        done_res;
    logic        failed;
    logic [31:0] rtt_average;
    logic [15:0] acked_total;
  } out_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] start;
    logic [32:0] timeout;
    logic [2:0]  retries;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_ACK_MUL,
    ST_ACK_DIV,
    ST_ACK_FIN,
    ST_TICK,
    ST_SCAN_RD,
    ST_SCAN,
    ST_RTX_RD,
    ST_RTX,
    ST_RTX_DIV,
    ST_RTX_WB,
    ST_OUT_RD,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/gbn_div.sv @@
// ----------------------------------------------------------------------------
// gbn_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gbn_pkg::DVD_W-1:0] dividend,
  input  logic [gbn_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [gbn_pkg::DVD_W-1:0] quotient
);

  logic                      busy;
  logic [gbn_pkg::DCW-1:0]   cnt;
  logic [gbn_pkg::DVS_W:0]   rem;
  logic [gbn_pkg::DVS_W:0]   rem_sh;
  logic [gbn_pkg::DVS_W:0]   rem_next;
  logic [gbn_pkg::DVS_W-1:0] dvs;
  logic [gbn_pkg::DVD_W-1:0] quo;
  logic                      qbit;

  always_comb begin
    rem_sh   = {rem[gbn_pkg::DVS_W-1:0], quo[gbn_pkg::DVD_W-1]};
    qbit     = rem_sh >= {1'b0, dvs};
    rem_next = qbit ? rem_sh - {1'b0, dvs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= gbn_pkg::DCW'(gbn_pkg::DVD_W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[gbn_pkg::DVD_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == gbn_pkg::DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/gbn_ring.sv @@
// ----------------------------------------------------------------------------
// gbn_ring
// Window entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbn_ring #(
  parameter int DEPTH = gbn_pkg::WINDOW_MAX_DEF,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  gbn_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output gbn_pkg::entry_t rdata
);

  gbn_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/go_back_n_sender.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender - Go-Back-N ARQ sender, one request at a time
// Ack: an in-order ack that matches the head entry updates the RTT through
//   the 49-step shared divider; each result waits on out_ready.
// Tick: scans the N entries in flight; a timeout resends the whole window,
//   with a divide per entry once any ack was taken.
// Sync reset: counters and flags clear, base 1; entry memory is not cleared.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF,
  parameter int BUFFER_MAX = gbn_pkg::BUFFER_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gbn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gbn_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int BCW = $clog2(BUFFER_MAX + 1);

  gbn_pkg::state_t state, state_next;

  // configuration
  logic [4:0]  win_limit;
  logic [6:0]  buf_limit;
  logic [15:0] ack_target;

  // protocol state
  logic [15:0]    next_seq;
  logic [BCW-1:0] buffered;
  logic [CW-1:0]  in_flight;
  logic [15:0]    base;
  logic [AW-1:0]  head;
  logic [31:0]    rtt;
  logic [15:0]    acked;
  logic           failed;

  // per-request working registers
  gbn_pkg::in_t    req;
  logic [CW-1:0]   cnt;       // walk index through the window
  logic [CW-1:0]   rtx_n;     // retransmit results to deliver
  logic            head_vld;  // leading result still pending
  logic [2:0]      head_kind;
  logic [15:0]     head_seq;
  logic            snd;
  logic            expired;
  gbn_pkg::entry_t ent;
  logic [31:0]     e_r;
  logic [47:0]     mul_r;

  // memory and divider hookup
  logic            mem_we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  gbn_pkg::entry_t wdata;
  gbn_pkg::entry_t rdata;
  logic                      div_start;
  logic                      div_done;
  logic [gbn_pkg::DVD_W-1:0] div_dvd;
  logic [gbn_pkg::DVS_W-1:0] div_dvs;
  logic [gbn_pkg::DVD_W-1:0] div_q;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic          is_done;
  logic          ack_ok;
  logic [CW:0]   rd_sum, wr_sum;
  logic [AW-1:0] rd_slot, tick_slot, head_inc;
  logic [AW:0]   head_sum;
  logic [CW-1:0] wlim;
  logic [BCW-1:0] blim;
  logic           gen, send, behind;
  logic [BCW-1:0] buf1;
  logic [15:0]    nseq1, s, d;
  logic [31:0]    elapsed;
  logic [31:0]    div_sat;
  logic [32:0]    rtx_sum;
  logic [2:0]     ret_new;

  always_comb begin
    is_done = (acked >= ack_target) || failed;
    ack_ok  = !is_done && (in_data.ack_seq == base);

    // ring slots, wrap by one compare and subtract
    rd_sum  = (CW+1)'(head) + (CW+1)'(cnt);
    rd_slot = (rd_sum >= (CW+1)'(WINDOW_MAX)) ? AW'(rd_sum - (CW+1)'(WINDOW_MAX))
                                              : AW'(rd_sum);
    wr_sum    = (CW+1)'(head) + (CW+1)'(in_flight);
    tick_slot = (wr_sum >= (CW+1)'(WINDOW_MAX)) ? AW'(wr_sum - (CW+1)'(WINDOW_MAX))
                                                : AW'(wr_sum);
    head_sum  = (AW+1)'(head) + (AW+1)'(1);
    head_inc  = (head_sum == (AW+1)'(WINDOW_MAX)) ? '0 : AW'(head_sum);

    // register values above the build limits act as the limits
    wlim = (32'(win_limit) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(win_limit);
    blim = (32'(buf_limit) > BUFFER_MAX) ? BCW'(BUFFER_MAX) : BCW'(buf_limit);

    // tick: generate, then send the oldest buffered number
    gen    = ((BCW+1)'(buffered) + (BCW+1)'(1)) < (BCW+1)'(blim);
    buf1   = gen ? buffered + 1'b1 : buffered;
    nseq1  = gen ? next_seq + 16'd1 : next_seq;
    send   = (buf1 != '0) && (in_flight < wlim);
    s      = nseq1 - 16'(buf1) + 16'd1;
    d      = base - s;
    behind = (d != 16'd0) && !d[15];   // already acked, no window entry

    elapsed = req.now_time - rdata.start;
    div_sat = (|div_q[gbn_pkg::DVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
    rtx_sum = {1'b0, rtt} + {1'b0, div_q[31:0]};
    ret_new = (ent.retries == gbn_pkg::RETRY_SAT) ? ent.retries : ent.retries + 3'd1;
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func) begin
            if (ack_ok) begin
              state_next = (in_flight != '0) ? gbn_pkg::ST_ACK_RD : gbn_pkg::ST_ACK_FIN;
            end else begin
              state_next = gbn_pkg::ST_OUT;
            end
          end else begin
            state_next = is_done ? gbn_pkg::ST_OUT : gbn_pkg::ST_TICK;
          end
        end
      end
      gbn_pkg::ST_ACK_RD:  state_next = gbn_pkg::ST_ACK_CHK;
      gbn_pkg::ST_ACK_CHK: begin
        state_next = (rdata.seq == req.ack_seq) ? gbn_pkg::ST_ACK_MUL : gbn_pkg::ST_ACK_FIN;
      end
      gbn_pkg::ST_ACK_MUL: state_next = gbn_pkg::ST_ACK_DIV;
      gbn_pkg::ST_ACK_DIV: if (div_done) state_next = gbn_pkg::ST_ACK_FIN;
      gbn_pkg::ST_ACK_FIN: state_next = gbn_pkg::ST_OUT;
      gbn_pkg::ST_TICK:    state_next = gbn_pkg::ST_SCAN_RD;
      gbn_pkg::ST_SCAN_RD: begin
        if (cnt == in_flight) begin
          state_next = expired ? gbn_pkg::ST_RTX_RD : gbn_pkg::ST_OUT_RD;
        end else begin
          state_next = gbn_pkg::ST_SCAN;
        end
      end
      gbn_pkg::ST_SCAN:    state_next = gbn_pkg::ST_SCAN_RD;
      gbn_pkg::ST_RTX_RD: begin
        state_next = (cnt == in_flight) ? gbn_pkg::ST_OUT_RD : gbn_pkg::ST_RTX;
      end
      gbn_pkg::ST_RTX: begin
        state_next = (acked == 16'd0) ? gbn_pkg::ST_RTX_WB : gbn_pkg::ST_RTX_DIV;
      end
      gbn_pkg::ST_RTX_DIV: if (div_done) state_next = gbn_pkg::ST_RTX_WB;
      gbn_pkg::ST_RTX_WB:  state_next = gbn_pkg::ST_RTX_RD;
      gbn_pkg::ST_OUT_RD:  state_next = gbn_pkg::ST_OUT;
      gbn_pkg::ST_OUT: begin
        if (out_ready) begin
          if (head_vld) begin
            state_next = (rtx_n == '0) ? gbn_pkg::ST_IDLE : gbn_pkg::ST_OUT;
          end else begin
            state_next = out_data.last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_next = gbn_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs: handshake, memory port, divider operands, result fields
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = (state == gbn_pkg::ST_IDLE);
    out_valid = (state == gbn_pkg::ST_OUT);

    raddr  = rd_slot;
    mem_we = 1'b0;
    waddr  = rd_slot;
    wdata  = '{seq: ent.seq, start: req.now_time, timeout: '0, retries: ret_new};
    case (state)
      gbn_pkg::ST_TICK: begin
        mem_we = send && !behind;
        waddr  = tick_slot;
        wdata  = '{seq: s, start: req.now_time,
                   timeout: (s < gbn_pkg::SEQ_EARLY) ? gbn_pkg::TIMEOUT_FIRST : {rtt, 1'b0},
                   retries: 3'd0};
      end
      gbn_pkg::ST_RTX_WB: begin
        mem_we        = 1'b1;
        wdata.timeout = (ent.seq < gbn_pkg::SEQ_EARLY) ? gbn_pkg::TIMEOUT_RETX : {rtt, 1'b0};
      end
      default: ;
    endcase

    // one divider: ack average (a*rtt + e)/(a+1) or retransmit step e/a
    div_start = 1'b0;
    div_dvd   = gbn_pkg::DVD_W'(elapsed);
    div_dvs   = {1'b0, acked};
    case (state)
      gbn_pkg::ST_ACK_MUL: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, mul_r} + gbn_pkg::DVD_W'(e_r);
        div_dvs   = {1'b0, acked} + gbn_pkg::DVS_W'(1);
      end
      gbn_pkg::ST_RTX: div_start = (acked != 16'd0);
      default: ;
    endcase

    out_data.kind        = head_vld ? head_kind : gbn_pkg::KIND_RETX;
    out_data.seq         = head_vld ? head_seq : rdata.seq;
    out_data.last        = head_vld ? (rtx_n == '0)
                                    : ((CW+1)'(cnt) + (CW+1)'(1) == (CW+1)'(rtx_n));
    out_data.done_res    = is_done;
    out_data.failed      = failed;
    out_data.rtt_average = rtt;
    out_data.acked_total = acked;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gbn_pkg::ST_IDLE;
      win_limit   <= 5'd16;
      buf_limit   <= 7'd30;
      ack_target  <= 16'd100;
      next_seq    <= '0;
      buffered    <= '0;
      in_flight   <= '0;
      base        <= 16'd1;
      head        <= '0;
      rtt         <= '0;
      acked       <= '0;
      failed      <= 1'b0;
      head_vld    <= 1'b0;
      cnt         <= '0;
      rtx_n       <= '0;
      snd         <= 1'b0;
      expired     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          gbn_pkg::CFG_WIN_LIMIT:  win_limit  <= cfg_data[4:0];
          gbn_pkg::CFG_BUF_LIMIT:  buf_limit  <= cfg_data[6:0];
          gbn_pkg::CFG_ACK_TARGET: ack_target <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        gbn_pkg::ST_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            cnt      <= '0;
            rtx_n    <= '0;
            snd      <= 1'b0;
            expired  <= 1'b0;
            head_vld <= 1'b1;
            if (in_data.func) begin
              head_kind <= ack_ok ? gbn_pkg::KIND_TAKEN : gbn_pkg::KIND_IGNORED;
              head_seq  <= in_data.ack_seq;
            end else begin
              head_kind <= gbn_pkg::KIND_NONE;
              head_seq  <= '0;
            end
          end
        end
        gbn_pkg::ST_ACK_CHK: begin
          e_r   <= elapsed;
          mul_r <= acked * rtt;
        end
        gbn_pkg::ST_ACK_DIV: begin
          if (div_done) begin
            rtt       <= div_sat;
            head      <= head_inc;
            in_flight <= in_flight - 1'b1;
          end
        end
        gbn_pkg::ST_ACK_FIN: begin
          base <= base + 16'd1;
          if (acked != 16'hFFFF) acked <= acked + 16'd1;
        end
        gbn_pkg::ST_TICK: begin
          next_seq <= nseq1;
          buffered <= send ? buf1 - 1'b1 : buf1;
          if (send) begin
            snd       <= 1'b1;
            head_kind <= gbn_pkg::KIND_SEND;
            head_seq  <= s;
            if (!behind) in_flight <= in_flight + 1'b1;
          end
        end
        gbn_pkg::ST_SCAN_RD: begin
          if (cnt == in_flight) begin
            cnt      <= '0;
            head_vld <= snd || !expired;
          end
        end
        gbn_pkg::ST_SCAN: begin
          if ({1'b0, elapsed} > rdata.timeout) expired <= 1'b1;
          cnt <= cnt + 1'b1;
        end
        gbn_pkg::ST_RTX_RD: begin
          if (cnt == in_flight) begin
            rtx_n <= in_flight;
            cnt   <= '0;
          end
        end
        gbn_pkg::ST_RTX: begin
          ent <= rdata;
          e_r <= elapsed;
          if (acked == 16'd0) rtt <= elapsed;
        end
        gbn_pkg::ST_RTX_DIV: begin
          if (div_done) rtt <= rtx_sum[32] ? 32'hFFFF_FFFF : rtx_sum[31:0];
        end
        gbn_pkg::ST_RTX_WB: begin
          cnt <= cnt + 1'b1;
          if (ret_new > gbn_pkg::RETRY_LIMIT) failed <= 1'b1;
        end
        gbn_pkg::ST_OUT: begin
          if (out_ready) begin
            if (head_vld) head_vld <= 1'b0;
            else cnt <= cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  gbn_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    32'(in_flight) <= WINDOW_MAX)
    else $error("in-flight count above window depth");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == gbn_pkg::ST_ACK_DIV || state == gbn_pkg::ST_RTX_DIV))
    else $error("divider finished outside a divide state");
`endif

endmodule

@@ tb/tb_go_back_n_sender.sv @@
// ----------------------------------------------------------------------------
// tb_go_back_n_sender
// Self-checking bench for the Go-Back-N sender: a clocked driver and monitor
// with random idling on both channels, checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING        = 16;
  localparam int CYCLE_LIMIT = 3000000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  gbn_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  gbn_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = gbn_pkg::CFG_WIN_LIMIT;
  logic [15:0]   cfg_data = '0;

  go_back_n_sender DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // requests waiting for the driver, results waiting for the monitor
  gbn_pkg::in_t  pending_reqs[$];
  gbn_pkg::out_t expected_results[$];
  int   err_count = 0;
  int   reqs_sent = 0;
  int   results_seen = 0;
  int   cycles = 0;
  bit   no_idle = 1'b0;     // set by the sequence to run stretches without gaps
  logic [31:0] clock_us;    // time value carried by generated requests

  // --------------------------------------------------------------------------
  // Predicted sender state
  // --------------------------------------------------------------------------
  int          win_cfg = 16, buf_cfg = 30, max_cfg = 100;
  logic [15:0] gen_seq = '0;
  int          buffered = 0;
  int          in_flight = 0;
  logic [15:0] base_seq = 16'd1;
  int          head = 0;
  logic [15:0] ring_seq[RING];
  logic [31:0] ring_start[RING];
  logic [32:0] ring_timeout[RING];
  logic [2:0]  ring_retries[RING];
  logic [31:0] rtt_avg_q = '0;
  logic [15:0] acked = '0;
  bit          failed_q = 1'b0;

  function automatic bit sender_done();
    return (int'(acked) >= max_cfg) || failed_q;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Work out every result that one accepted request produces.
  task automatic predict_request(gbn_pkg::in_t r);
    logic [2:0]    kinds[RING+1];
    logic [15:0]   seqs[RING+1];
    int            n, slot, wl, bl;
    logic [31:0]   el;
    logic [15:0]   s, d;
    bit            expired;
    gbn_pkg::out_t o;
    n = 0;
    if (r.func) begin
      if (!sender_done() && r.ack_seq == base_seq) begin
        // RTT only moves when the head entry is the acked one
        if (in_flight > 0 && ring_seq[head] == r.ack_seq) begin
          el = r.now_time - ring_start[head];
          rtt_avg_q = sat32((64'(acked) * 64'(rtt_avg_q) + 64'(el)) / (64'(acked) + 64'd1));
          head = (head + 1) % RING;
          in_flight--;
        end
        base_seq = base_seq + 16'd1;
        if (acked != 16'hFFFF) acked = acked + 16'd1;
        kinds[0] = gbn_pkg::KIND_TAKEN;
      end else begin
        kinds[0] = gbn_pkg::KIND_IGNORED;
      end
      seqs[0] = r.ack_seq;
      n = 1;
    end else if (!sender_done()) begin
      bl = (buf_cfg > 64) ? 64 : buf_cfg;
      wl = (win_cfg > RING) ? RING : win_cfg;
      if (buffered + 1 < bl) begin
        gen_seq = gen_seq + 16'd1;
        buffered++;
      end
      if (buffered > 0 && in_flight < wl) begin
        s = gen_seq - 16'(buffered) + 16'd1;
        d = base_seq - s;
        buffered--;
        // a number already behind the base is reported but not tracked
        if (!(d >= 16'd1 && d <= 16'd32767)) begin
          slot = (head + in_flight) % RING;
          ring_seq[slot]     = s;
          ring_start[slot]   = r.now_time;
          ring_timeout[slot] = (s < gbn_pkg::SEQ_EARLY) ? gbn_pkg::TIMEOUT_FIRST
                                                        : (33'(rtt_avg_q) << 1);
          ring_retries[slot] = '0;
          in_flight++;
        end
        kinds[n] = gbn_pkg::KIND_SEND;
        seqs[n]  = s;
        n++;
      end
      expired = 1'b0;
      for (int i = 0; i < in_flight; i++) begin
        slot = (head + i) % RING;
        el = r.now_time - ring_start[slot];
        if (33'(el) > ring_timeout[slot]) expired = 1'b1;
      end
      if (expired) begin
        // resend the whole window, oldest first
        for (int i = 0; i < in_flight; i++) begin
          slot = (head + i) % RING;
          el = r.now_time - ring_start[slot];
          if (acked == 0) rtt_avg_q = el;
          else rtt_avg_q = sat32(64'(rtt_avg_q) + 64'(el / acked));
          ring_start[slot]   = r.now_time;
          ring_timeout[slot] = (ring_seq[slot] < gbn_pkg::SEQ_EARLY) ? gbn_pkg::TIMEOUT_RETX
                                                                     : (33'(rtt_avg_q) << 1);
          if (ring_retries[slot] < gbn_pkg::RETRY_SAT)
            ring_retries[slot] = ring_retries[slot] + 3'd1;
          if (ring_retries[slot] > gbn_pkg::RETRY_LIMIT) failed_q = 1'b1;
          kinds[n] = gbn_pkg::KIND_RETX;
          seqs[n]  = ring_seq[slot];
          n++;
        end
      end
    end
    if (n == 0) begin
      kinds[0] = gbn_pkg::KIND_NONE;
      seqs[0]  = '0;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      o.kind        = kinds[k];
      o.seq         = seqs[k];
      o.last        = (k == n - 1);
      o.done_res    = sender_done();
      o.failed      = failed_q;
      o.rtt_average = rtt_avg_q;
      o.acked_total = acked;
      expected_results.push_back(o);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  int in_gap = 0;
  always @(posedge clk) begin : driver
    bit taken;
    taken = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        predict_request(in_data);
        reqs_sent++;
      end
      if (!in_valid || taken) begin
        if (in_gap > 0 && !no_idle) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
          in_gap   = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  int out_gap = 0;
  always @(posedge clk) begin : monitor
    gbn_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d seq 0x%0h",
               out_data.kind, out_data.seq);
        err_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, out_data.kind);
        check_field("seq", e.seq, out_data.seq);
        check_field("last", e.last, out_data.last);
        check_field("done_res", e.done_res, out_data.done_res);
        check_field("failed", e.failed, out_data.failed);
        check_field("rtt_average", e.rtt_average, out_data.rtt_average);
        check_field("acked_total", e.acked_total, out_data.acked_total);
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0 && !no_idle) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = draw_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      gbn_pkg::CFG_WIN_LIMIT: win_cfg = val & 16'h1F;
      gbn_pkg::CFG_BUF_LIMIT: buf_cfg = val & 16'h7F;
      default:                max_cfg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(int unsigned dt);
    gbn_pkg::in_t r;
    clock_us = clock_us + dt;
    r.func = 1'b0;
    r.ack_seq = 16'($urandom);
    r.now_time = clock_us;
    pending_reqs.push_back(r);
  endtask

  task automatic push_ack(logic [15:0] sq, int unsigned dt);
    gbn_pkg::in_t r;
    clock_us = clock_us + dt;
    r.func = 1'b1;
    r.ack_seq = sq;
    r.now_time = clock_us;
    pending_reqs.push_back(r);
  endtask

  // wait until every queued request has been taken by the block
  task automatic settle_requests();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
  endtask

  // full idle: nothing queued, nothing outstanding
  task automatic drain();
    settle_requests();
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  function automatic int unsigned short_dt();
    if ($urandom_range(0, 7) == 0) return $urandom_range(50000, 400000);
    return $urandom_range(0, 3000);
  endfunction

  // a mix of tick bursts and in-order acks, with a little noise
  task automatic random_phase(int count);
    int made, k;
    made = 0;
    while (made < count) begin
      settle_requests();
      if (in_flight > 0 && ring_retries[head] >= 3'd3) begin
        // keep an old packet from running out of retries
        push_ack(base_seq, $urandom_range(0, 2000));
        made++;
      end else if ($urandom_range(0, 2) != 0) begin
        k = $urandom_range(1, 4);
        repeat (k) push_tick(short_dt());
        made += k;
      end else if ($urandom_range(0, 4) == 0) begin
        push_ack(16'($urandom), $urandom_range(0, 5000));
        made++;
      end else begin
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) push_ack(base_seq + 16'(j), $urandom_range(0, 5000));
        made += k;
      end
    end
  endtask

  initial begin
    clock_us = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored acks at both ends of the field, ack of an unsent number
    push_ack(16'h0000, 5);
    push_ack(16'hFFFF, 5);
    push_ack(16'd1, 5);
    push_tick(10);            // seq 1 now lies behind the base
    push_tick(10);
    settle_requests();
    push_ack(base_seq, 1234); // in-order ack with an RTT update
    repeat (4) push_tick(100);
    clock_us = 32'hFFFF_FF00; // time wraps within the next step
    push_tick(150000);        // everything in flight expires
    settle_requests();
    push_ack(base_seq, 700);
    push_ack(base_seq + 16'd1, 700);
    drain();

    // finished by count: ticks are quiet, acks are ignored
    write_reg(gbn_pkg::CFG_ACK_TARGET, 16'd1);
    push_tick(10);
    push_ack(base_seq, 10);
    drain();
    write_reg(gbn_pkg::CFG_ACK_TARGET, 16'hFFFF);

    // random phases over several window and buffer settings
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'd1);
    write_reg(gbn_pkg::CFG_BUF_LIMIT, 16'd2);
    random_phase(20);
    drain();
    no_idle = 1'b1;
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'd16);
    write_reg(gbn_pkg::CFG_BUF_LIMIT, 16'd64);
    random_phase(20);
    drain();
    no_idle = 1'b0;
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'd31);
    write_reg(gbn_pkg::CFG_BUF_LIMIT, 16'd127);
    random_phase(20);
    drain();
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'd4);
    write_reg(gbn_pkg::CFG_BUF_LIMIT, 16'd8);
    random_phase(20);
    drain();
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'($urandom_range(1, 16)));
    write_reg(gbn_pkg::CFG_BUF_LIMIT, 16'($urandom_range(2, 64)));
    random_phase(20);
    drain();

    // no acks and long silences until some packet gives up
    write_reg(gbn_pkg::CFG_WIN_LIMIT, 16'd16);
    push_tick(10);
    repeat (8) push_tick(32'd2_000_000_000);
    push_tick(10);
    push_ack(base_seq, 10);
    drain();

    $display("%0d requests driven, %0d results checked, %0d acks taken",
             reqs_sent, results_seen, acked);
    $display("covered window 1..31, buffer 2..127, done by count and by retries");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_div.sv
hw/rtl/gbn_ring.sv
hw/rtl/go_back_n_sender.sv
tb/tb_go_back_n_sender.sv
